[rtl/core/transposition_table_probe_store_defines.svh]
// assertion macros for the transposition table probe store
// used by the top level; expects clk and rst_n in scope
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_DEFINES_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define TTPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttps assertion failed");

`define TTPS_ASSERT_LAT3(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
    else $error("ttps latency assertion failed");

`else

`define TTPS_ASSERT_NOW(label, ante, cons)

`define TTPS_ASSERT_LAT3(label, ante, cons)

`endif

`endif

[rtl/core/ttps_pkg.sv]
// shared types and constants of the transposition table probe store
// no dependencies
package ttps_pkg;

  localparam int ENTRIES = 65536;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int KEY_W   = 64;
  localparam int EVAL_W  = 24;
  localparam int DEPTH_W = 8;
  localparam int VAL_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS = 2'd1;

  localparam logic signed [EVAL_W-1:0] WIN_RESET  = 24'sd100000;
  localparam logic signed [EVAL_W-1:0] LOSS_RESET = -24'sd100000;

  localparam logic signed [VAL_W-1:0] ORDER_TOP  = 32'sd1000000;
  localparam logic signed [VAL_W-1:0] ORDER_NONE = -32'sd1000000;

  typedef enum logic [1:0] {
    OP_PROBE  = 2'd0,
    OP_STORE  = 2'd1,
    OP_ORDER  = 2'd2,
    OP_DEMOTE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_EXACT = 2'd0,
    KIND_ALPHA = 2'd1,
    KIND_BETA  = 2'd2,
    KIND_LAST  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [KEY_W-1:0]          tag;
    logic signed [EVAL_W-1:0]  eval;
    kind_t                     kind;
    logic [DEPTH_W-1:0]        depth;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic clr_we;
    logic capture;
    logic evaluate;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_status_t;

endpackage

[rtl/core/ttps_ram.sv]
// generic single-port-write, registered-read ram
// no dependencies
module ttps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/ttps_ctrl.sv]
// controller: clearing pass, read and evaluate sequencing
// depends on ttps_pkg
module ttps_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  ttps_pkg::dp_status_t   status,
  output ttps_pkg::ctrl_cmd_t    cmd
);
  import ttps_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EVAL  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign busy   = (state_r == ST_CLEAR) || (state_r == ST_READ);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (status.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = start ? ST_READ : ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.clr_we   = (state_r == ST_CLEAR);
  assign cmd.capture  = accept;
  assign cmd.evaluate = (state_r == ST_EVAL);

endmodule

[rtl/core/ttps_dp.sv]
// datapath: table ram, config registers, probe/store/order/demote evaluation
// depends on ttps_pkg and ttps_ram
module ttps_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ttps_pkg::ctrl_cmd_t                 cmd,
  output ttps_pkg::dp_status_t                status,
  input  logic                                cfg_we,
  input  logic [ttps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ttps_pkg::EVAL_W-1:0]         cfg_data,
  input  logic [1:0]                          in_opcode,
  input  logic [ttps_pkg::KEY_W-1:0]          in_position_key,
  input  logic [ttps_pkg::DEPTH_W-1:0]        in_search_depth,
  input  logic signed [ttps_pkg::EVAL_W-1:0]  in_lower_bound_in,
  input  logic signed [ttps_pkg::EVAL_W-1:0]  in_upper_bound_in,
  input  logic signed [ttps_pkg::EVAL_W-1:0]  in_store_eval,
  input  logic [1:0]                          in_store_flag,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic signed [ttps_pkg::VAL_W-1:0]   out_value
);
  import ttps_pkg::*;

  logic signed [EVAL_W-1:0] win_r, loss_r;
  logic [IDX_W-1:0]         clr_addr_r;

  op_t                      op_r;
  logic [KEY_W-1:0]         key_r;
  logic [DEPTH_W-1:0]       depth_r;
  logic signed [EVAL_W-1:0] lo_r, hi_r, seval_r;
  kind_t                    sflag_r;
  logic                     byp_r;
  entry_t                   byp_data_r;

  logic [ENTRY_W-1:0] ram_q;
  entry_t             cur;
  entry_t             wentry;
  logic               item_we;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   slot_r, in_slot;

  logic                      match, deep_enough, is_win, is_loss;
  logic signed [EVAL_W:0]    adj, lo_x, hi_x, ev_x, dep_x;
  logic                      hit_nxt;
  logic signed [VAL_W-1:0]   val_nxt;

  assign in_slot = in_position_key[IDX_W-1:0];
  assign slot_r  = key_r[IDX_W-1:0];

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= WIN_RESET;
      loss_r <= LOSS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIN:  win_r  <= cfg_data;
        CFG_LOSS: loss_r <= cfg_data;
        default:  ;
      endcase
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_we) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign status.clr_last = (clr_addr_r == {IDX_W{1'b1}});

  // item capture and write-to-read forwarding
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= op_t'(in_opcode);
      key_r      <= in_position_key;
      depth_r    <= in_search_depth;
      lo_r       <= in_lower_bound_in;
      hi_r       <= in_upper_bound_in;
      seval_r    <= in_store_eval;
      sflag_r    <= kind_t'(in_store_flag);
      byp_data_r <= wentry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (cmd.capture) begin
      byp_r <= item_we && (in_slot == slot_r);
    end
  end

  assign cur = byp_r ? byp_data_r : entry_t'(ram_q);

  // evaluation
  assign match       = (cur.tag == key_r);
  assign deep_enough = (cur.depth >= depth_r);
  assign is_win      = (cur.eval >= win_r);
  assign is_loss     = (cur.eval <= loss_r);
  assign ev_x        = {cur.eval[EVAL_W-1], cur.eval};
  assign dep_x       = {{(EVAL_W+1-DEPTH_W){1'b0}}, depth_r};
  assign lo_x        = {lo_r[EVAL_W-1], lo_r};
  assign hi_x        = {hi_r[EVAL_W-1], hi_r};

  always_comb begin
    if (is_win) begin
      adj = ev_x - dep_x;
    end else if (is_loss) begin
      adj = ev_x + dep_x;
    end else begin
      adj = ev_x;
    end
  end

  always_comb begin
    hit_nxt = 1'b0;
    val_nxt = '0;
    wentry  = cur;
    item_we = 1'b0;
    case (op_r)
      OP_PROBE: begin
        if (match && deep_enough) begin
          case (cur.kind)
            KIND_EXACT, KIND_LAST: begin
              hit_nxt = 1'b1;
              val_nxt = VAL_W'(adj);
            end
            KIND_ALPHA: begin
              if (adj <= lo_x) begin
                hit_nxt = 1'b1;
                val_nxt = VAL_W'(lo_r);
              end
            end
            default: begin
              if (adj >= hi_x) begin
                hit_nxt = 1'b1;
                val_nxt = VAL_W'(hi_r);
              end
            end
          endcase
        end
      end
      OP_STORE: begin
        wentry.tag   = key_r;
        wentry.eval  = seval_r;
        wentry.kind  = sflag_r;
        wentry.depth = depth_r;
        item_we      = cmd.evaluate;
      end
      OP_ORDER: begin
        val_nxt = ORDER_NONE;
        if (match) begin
          case (cur.kind)
            KIND_LAST: begin
              hit_nxt = 1'b1;
              val_nxt = ORDER_TOP + VAL_W'(cur.depth);
            end
            KIND_EXACT, KIND_ALPHA: begin
              hit_nxt = 1'b1;
              val_nxt = VAL_W'(cur.eval);
            end
            default: ;
          endcase
        end
      end
      default: begin
        if (match) begin
          hit_nxt     = 1'b1;
          wentry.kind = KIND_EXACT;
          item_we     = cmd.evaluate;
        end
      end
    endcase
  end

  // ram write port shared by clearing pass and item write-back
  always_comb begin
    if (cmd.clr_we) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = item_we;
      ram_waddr = slot_r;
      ram_wdata = wentry;
    end
  end

  ttps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.capture),
    .raddr (in_slot),
    .rdata (ram_q)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.evaluate;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.evaluate) begin
      out_hit   <= hit_nxt;
      out_value <= val_nxt;
    end
  end

endmodule

[rtl/core/transposition_table_probe_store.sv]
// top level of the transposition table probe store
// depends on ttps_pkg, ttps_ctrl, ttps_dp and the assertion header
//
// usage:
//   command channel: present an operation on the in_* ports with start high;
//   it is taken at a clock edge where start is high and busy is low.
//   result channel: out_valid pulses for one cycle with out_hit and out_value;
//   there is no back-pressure, the receiver must take every result.
//   config channel: cfg_valid/cfg_ready with cfg_index (0 win threshold,
//   1 loss threshold) and cfg_data; cfg_ready is always high, other indexes
//   are ignored. write only while no operation is in flight.
// result: after the command transfer the controller steps through the read state
//   and the evaluate state, and out_valid is registered from the evaluate state.
// overlap: busy is high in the table read state; the next operation can be taken
//   in the evaluate and write-back state of the last one, and a result and the next
//   transfer can happen in the same cycle.
// reset: synchronous, active low. thresholds return to their reset values and
//   a clearing pass zeroes the 65536-entry table, one entry a cycle, with busy
//   high until the pass ends; config writes are taken meanwhile.
module transposition_table_probe_store (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_opcode,
  input  logic [ttps_pkg::KEY_W-1:0]          in_position_key,
  input  logic [ttps_pkg::DEPTH_W-1:0]        in_search_depth,
  input  logic signed [ttps_pkg::EVAL_W-1:0]  in_lower_bound_in,
  input  logic signed [ttps_pkg::EVAL_W-1:0]  in_upper_bound_in,
  input  logic signed [ttps_pkg::EVAL_W-1:0]  in_store_eval,
  input  logic [1:0]                          in_store_flag,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic signed [ttps_pkg::VAL_W-1:0]   out_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ttps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ttps_pkg::EVAL_W-1:0]         cfg_data
);
  import ttps_pkg::*;

  `include "transposition_table_probe_store_defines.svh"

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  ttps_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  ttps_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_opcode         (in_opcode),
    .in_position_key   (in_position_key),
    .in_search_depth   (in_search_depth),
    .in_lower_bound_in (in_lower_bound_in),
    .in_upper_bound_in (in_upper_bound_in),
    .in_store_eval     (in_store_eval),
    .in_store_flag     (in_store_flag),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_value         (out_value)
  );

  `TTPS_ASSERT_LAT3(a_result_latency, accept, out_valid)
  `TTPS_ASSERT_NOW(a_no_spurious_result, out_valid, $past(accept, 3))
  `TTPS_ASSERT_NOW(a_clear_never_writes_item, cmd.clr_we, !cmd.evaluate && !out_valid)

endmodule
